@@ rtl/mau_pkg.sv @@
// Shared types, codes and constants of the modular arithmetic unit.
package mau_pkg;

  localparam int RESIDUE_WIDTH = 30;
  localparam logic [29:0] RESET_MODULUS = 30'd1000000007;
  localparam int FIELD_WIDTH = 30;
  localparam int WIDE_WIDTH = 64;
  localparam int EXP_WIDTH = 63;
  localparam int RED_STEPS = 64;

  typedef enum logic [2:0] {
    CMD_REDUCE   = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_SUBTRACT = 3'd2,
    CMD_MULTIPLY = 3'd3,
    CMD_DIVIDE   = 3'd4,
    CMD_POWER    = 3'd5,
    CMD_NEGATE   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_A, SRC_B, SRC_WIDE, SRC_PROD
  } src_t;

  typedef enum logic [2:0] {
    DST_A, DST_B, DST_ACC, DST_BASE, DST_RES
  } dst_t;

  typedef enum logic [1:0] {
    MUL_AB, MUL_ACC_BASE, MUL_BASE_BASE, MUL_ACC_A
  } mul_t;

  typedef enum logic [2:0] {
    FIN_RES, FIN_WIDE, FIN_ADD, FIN_SUB, FIN_NEG, FIN_ACC, FIN_DZ, FIN_ZERO
  } fin_t;

  typedef struct packed {
    logic load;
    logic red_go;
    logic mul_go;
    src_t src;
    dst_t dst;
    mul_t mul_sel;
    logic pow_init;
    logic div_init;
    logic shift_exp;
    logic wr_out;
    fin_t fin_sel;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic done;
    logic b_zero;
    logic exp_zero;
    logic exp_lsb;
    logic out_full;
  } stat_t;

endpackage

@@ rtl/mau_ctrl.sv @@
// Controller state machine that sequences reductions, multiplies and power rounds.
module mau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  mau_pkg::stat_t st,
  output mau_pkg::ctrl_t cm
);

  typedef enum logic [3:0] {
    S_IDLE, S_RA_GO, S_RA_W, S_RB_GO, S_RB_W, S_DISPATCH, S_WIDE_W, S_MUL_W,
    S_PCHK, S_PACC_W, S_PSQ_GO, S_PSQ_W, S_DIVM, S_FIN
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:     if (s_tvalid) state <= S_RA_GO;
        S_RA_GO:    state <= S_RA_W;
        S_RA_W:     if (st.done) state <= S_RB_GO;
        S_RB_GO:    state <= S_RB_W;
        S_RB_W:     if (st.done) state <= S_DISPATCH;
        S_DISPATCH: begin
          unique case (st.cmd)
            mau_pkg::CMD_REDUCE:   state <= S_WIDE_W;
            mau_pkg::CMD_MULTIPLY: state <= S_MUL_W;
            mau_pkg::CMD_DIVIDE:   state <= st.b_zero ? S_FIN : S_PCHK;
            mau_pkg::CMD_POWER:    state <= S_PCHK;
            default:               state <= S_FIN;
          endcase
        end
        S_WIDE_W:   if (st.done) state <= S_FIN;
        S_MUL_W:    if (st.done) state <= S_FIN;
        S_PCHK: begin
          priority if (st.exp_zero) begin
            state <= (st.cmd == mau_pkg::CMD_DIVIDE) ? S_DIVM : S_FIN;
          end else if (st.exp_lsb) begin
            state <= S_PACC_W;
          end else begin
            state <= S_PSQ_GO;
          end
        end
        S_PACC_W:   if (st.done) state <= S_PSQ_GO;
        S_PSQ_GO:   state <= S_PSQ_W;
        S_PSQ_W:    if (st.done) state <= S_PCHK;
        S_DIVM:     state <= S_MUL_W;
        S_FIN:      if (!st.out_full) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cm = '0;
    cm.src = mau_pkg::SRC_A;
    cm.dst = mau_pkg::DST_A;
    cm.mul_sel = mau_pkg::MUL_AB;
    unique case (st.cmd)
      mau_pkg::CMD_REDUCE:   cm.fin_sel = mau_pkg::FIN_WIDE;
      mau_pkg::CMD_ADD:      cm.fin_sel = mau_pkg::FIN_ADD;
      mau_pkg::CMD_SUBTRACT: cm.fin_sel = mau_pkg::FIN_SUB;
      mau_pkg::CMD_MULTIPLY: cm.fin_sel = mau_pkg::FIN_RES;
      mau_pkg::CMD_DIVIDE:   cm.fin_sel = st.b_zero ? mau_pkg::FIN_DZ : mau_pkg::FIN_RES;
      mau_pkg::CMD_POWER:    cm.fin_sel = mau_pkg::FIN_ACC;
      mau_pkg::CMD_NEGATE:   cm.fin_sel = mau_pkg::FIN_NEG;
      default:               cm.fin_sel = mau_pkg::FIN_ZERO;
    endcase
    unique case (state)
      S_IDLE:  cm.load = s_tvalid;
      S_RA_GO: begin
        cm.red_go = 1'b1;
        cm.src = mau_pkg::SRC_A;
        cm.dst = mau_pkg::DST_A;
      end
      S_RB_GO: begin
        cm.red_go = 1'b1;
        cm.src = mau_pkg::SRC_B;
        cm.dst = mau_pkg::DST_B;
      end
      S_DISPATCH: begin
        unique case (st.cmd)
          mau_pkg::CMD_REDUCE: begin
            cm.red_go = 1'b1;
            cm.src = mau_pkg::SRC_WIDE;
            cm.dst = mau_pkg::DST_RES;
          end
          mau_pkg::CMD_MULTIPLY: begin
            cm.mul_go = 1'b1;
            cm.mul_sel = mau_pkg::MUL_AB;
            cm.dst = mau_pkg::DST_RES;
          end
          mau_pkg::CMD_DIVIDE: cm.div_init = !st.b_zero;
          mau_pkg::CMD_POWER:  cm.pow_init = 1'b1;
          default: ;
        endcase
      end
      S_PCHK: begin
        if (!st.exp_zero && st.exp_lsb) begin
          cm.mul_go = 1'b1;
          cm.mul_sel = mau_pkg::MUL_ACC_BASE;
          cm.dst = mau_pkg::DST_ACC;
        end
      end
      S_PSQ_GO: begin
        cm.mul_go = 1'b1;
        cm.mul_sel = mau_pkg::MUL_BASE_BASE;
        cm.dst = mau_pkg::DST_BASE;
        cm.shift_exp = 1'b1;
      end
      S_DIVM: begin
        cm.mul_go = 1'b1;
        cm.mul_sel = mau_pkg::MUL_ACC_A;
        cm.dst = mau_pkg::DST_RES;
      end
      S_FIN: cm.wr_out = !st.out_full;
      default: ;
    endcase
  end

endmodule

@@ rtl/mau_datapath.sv @@
// Datapath: operand registers, multiplier, bit-serial remainder unit and output register.
module mau_datapath #(
  parameter int RESIDUE_WIDTH = mau_pkg::RESIDUE_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [29:0]    cfg_data,
  input  logic [2:0]     s_tuser,
  input  logic [191:0]   s_tdata,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata,
  output logic           m_tuser,
  input  mau_pkg::ctrl_t cm,
  output mau_pkg::stat_t st
);

  localparam int W = RESIDUE_WIDTH;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] RST_RAW = W'(mau_pkg::RESET_MODULUS);
  localparam logic [W-1:0] RST_MOD = (RST_RAW < W'(2)) ? W'(2) : RST_RAW;

  logic [W-1:0]  modulus;
  mau_pkg::cmd_t cmd_r;
  logic [29:0]   a_raw, b_raw;
  logic [63:0]   wide_r;
  logic [62:0]   exp_r;
  logic [W-1:0]  a_r, b_r, acc_r, base_r, res_r;
  logic [PW-1:0] prod;
  logic [63:0]   x_r;
  logic [W-1:0]  r_r;
  logic [5:0]    cnt;
  logic          busy, done, pend;
  mau_pkg::dst_t dst_r;
  logic          out_valid, out_dz;
  logic [W-1:0]  out_data;

  logic [W-1:0]  cfg_low;
  logic [63:0]   src_val;
  logic [W:0]    t, tsub;
  logic [W-1:0]  r_new;
  logic [W-1:0]  mx, my;
  logic [W:0]    add_s, add_m, sub_v;
  logic [W-1:0]  fin_val;

  assign cfg_low = cfg_data[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RST_MOD;
    end else if (cfg_we) begin
      modulus <= (cfg_low < W'(2)) ? W'(2) : cfg_low;
    end
  end

  always_comb begin
    unique case (cm.src)
      mau_pkg::SRC_A:    src_val = 64'(a_raw);
      mau_pkg::SRC_B:    src_val = 64'(b_raw);
      mau_pkg::SRC_WIDE: src_val = wide_r[63] ? (64'd0 - wide_r) : wide_r;
      default:           src_val = 64'(prod);
    endcase
  end

  // one remainder bit per cycle; r stays below the modulus
  assign t = {r_r, x_r[63]};
  assign tsub = t - {1'b0, modulus};
  assign r_new = (t >= {1'b0, modulus}) ? tsub[W-1:0] : t[W-1:0];

  always_comb begin
    unique case (cm.mul_sel)
      mau_pkg::MUL_AB:        begin mx = a_r;    my = b_r;    end
      mau_pkg::MUL_ACC_BASE:  begin mx = acc_r;  my = base_r; end
      mau_pkg::MUL_BASE_BASE: begin mx = base_r; my = base_r; end
      default:                begin mx = acc_r;  my = a_r;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pend <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      pend <= 1'b0;
      if (cm.mul_go) begin
        pend <= 1'b1;
        dst_r <= cm.dst;
      end
      if (pend) begin
        busy <= 1'b1;
        cnt <= '0;
        x_r <= 64'(prod);
        r_r <= '0;
      end else if (cm.red_go) begin
        busy <= 1'b1;
        cnt <= '0;
        x_r <= src_val;
        r_r <= '0;
        dst_r <= cm.dst;
      end else if (busy) begin
        x_r <= x_r << 1;
        r_r <= r_new;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(mau_pkg::RED_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          unique case (dst_r)
            mau_pkg::DST_A:    a_r <= r_new;
            mau_pkg::DST_B:    b_r <= r_new;
            mau_pkg::DST_ACC:  acc_r <= r_new;
            mau_pkg::DST_BASE: base_r <= r_new;
            default:           res_r <= r_new;
          endcase
        end
      end
      if (cm.pow_init) begin
        base_r <= a_r;
        acc_r <= W'(1);
      end
      if (cm.div_init) begin
        base_r <= b_r;
        acc_r <= W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cm.mul_go) prod <= PW'(mx) * PW'(my);
  end

  always_ff @(posedge clk) begin
    if (cm.load) begin
      cmd_r <= mau_pkg::cmd_t'(s_tuser);
      a_raw <= s_tdata[29:0];
      b_raw <= s_tdata[59:30];
      wide_r <= s_tdata[123:60];
      exp_r <= s_tdata[186:124];
    end else if (cm.div_init) begin
      exp_r <= 63'(modulus) - 63'd2;
    end else if (cm.shift_exp) begin
      exp_r <= exp_r >> 1;
    end
  end

  assign add_s = {1'b0, a_r} + {1'b0, b_r};
  assign add_m = add_s - {1'b0, modulus};
  assign sub_v = (a_r >= b_r) ? ({1'b0, a_r} - {1'b0, b_r})
                              : ({1'b0, a_r} + {1'b0, modulus} - {1'b0, b_r});

  always_comb begin
    unique case (cm.fin_sel)
      mau_pkg::FIN_RES:  fin_val = res_r;
      mau_pkg::FIN_WIDE: fin_val = (wide_r[63] && res_r != '0) ? modulus - res_r : res_r;
      mau_pkg::FIN_ADD:  fin_val = (add_s >= {1'b0, modulus}) ? add_m[W-1:0] : add_s[W-1:0];
      mau_pkg::FIN_SUB:  fin_val = sub_v[W-1:0];
      mau_pkg::FIN_NEG:  fin_val = (a_r == '0) ? '0 : modulus - a_r;
      mau_pkg::FIN_ACC:  fin_val = acc_r;
      default:           fin_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cm.wr_out) begin
      out_valid <= 1'b1;
      out_data <= fin_val;
      out_dz <= (cm.fin_sel == mau_pkg::FIN_DZ);
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = 32'(out_data);
  assign m_tuser = out_dz;

  assign st.cmd = cmd_r;
  assign st.done = done;
  assign st.b_zero = (b_r == '0);
  assign st.exp_zero = (exp_r == '0);
  assign st.exp_lsb = exp_r[0];
  assign st.out_full = out_valid;

endmodule

@@ rtl/modular_arithmetic_unit.sv @@
// Top level of the modular arithmetic unit: controller plus datapath.
//
// Requests arrive on the s_ stream: s_tuser carries the command, s_tdata the
// operands. Each request yields exactly one response on the m_ stream: the
// residue in m_tdata and the divide-by-zero flag in m_tuser.
// The modulus is written through cfg_we/cfg_data; the user must write it only
// while the unit is idle, as the unit does not enforce this. A value below 2
// is stored as 2. Reset loads 1000000007 and empties the unit. One request is
// processed at a time. Every reduction runs through a bit-serial remainder
// unit. Both operands are reduced first. Add, subtract and negate then finish
// directly; reduce and multiply take one more reduction; power takes one
// squaring per exponent bit plus one multiply per set bit of an exponent of
// up to 63 bits; divide raises b to the modulus minus 2 the same way, then
// multiplies by a. The next request is taken while a response waits in the
// output register; a stalled response is held until m_tready.
module modular_arithmetic_unit #(
  parameter int RESIDUE_WIDTH = mau_pkg::RESIDUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [29:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // value_a, value_b, wide_value, exponent, zero pad
  input  logic [2:0]   s_tuser,  // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // result, zero pad
  output logic         m_tuser   // divide_by_zero
);

  mau_pkg::ctrl_t cm;
  mau_pkg::stat_t st;

  mau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .st(st), .cm(cm)
  );

  mau_datapath #(.RESIDUE_WIDTH(RESIDUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cm(cm), .st(st)
  );

endmodule

@@ rtl/mau_checker.sv @@
// Port-level checker for the modular arithmetic unit and its bind.
module mau_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("response dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("response changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0) else $error("divide by zero with nonzero result");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("request taken while busy");

  a_dz_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != mau_pkg::CMD_DIVIDE
    |=> !(m_tvalid && m_tuser && !$past(m_tvalid)))
    else $error("flag raised for a non-divide request");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (.*);
